// ===== hdl/wsfd_pkg.sv =====
// Shared types, codes and constants of the WebSocket frame deframer.
package wsfd_pkg;

    // Configuration registers
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGE_LEN = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_RESET_LEN       = 23'd65536;

    // Frame opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // Result status codes
    localparam logic [2:0] ST_DATA      = 3'd0;
    localparam logic [2:0] ST_PING      = 3'd1;
    localparam logic [2:0] ST_CLOSE     = 3'd2;
    localparam logic [2:0] ST_FRAME_BIG = 3'd3;
    localparam logic [2:0] ST_MSG_BIG   = 3'd4;
    localparam logic [2:0] ST_ABANDON   = 3'd5;

    // Header byte fields
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [6:0] PING_MAX    = 7'd125;
    localparam logic [2:0] EXT16_START = 3'd6;
    localparam logic [2:0] EXT_LAST    = 3'd7;
    localparam logic [2:0] MASK_LAST   = 3'd3;

    // Result queue between parser and output side
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } wsfd_phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic [3:0] msg_opcode;
        logic       message_end;
        logic [2:0] status;
        logic       last_result;
    } wsfd_res_t;

    // Up to two results written into the queue for one accepted byte.
    typedef struct packed {
        logic [1:0] count;
        wsfd_res_t  e0;
        wsfd_res_t  e1;
    } wsfd_wr_t;

    function automatic wsfd_res_t mk_marker(input logic [3:0] op, input logic fin_msg,
                                            input logic [2:0] st);
        wsfd_res_t r;
        r.payload_byte = 8'h00;
        r.byte_valid   = 1'b0;
        r.msg_opcode   = op;
        r.message_end  = fin_msg;
        r.status       = st;
        r.last_result  = 1'b0;
        return r;
    endfunction

    function automatic wsfd_res_t mk_data(input logic [7:0] data, input logic [3:0] op,
                                          input logic fin_msg, input logic [2:0] st);
        wsfd_res_t r;
        r.payload_byte = data;
        r.byte_valid   = 1'b1;
        r.msg_opcode   = op;
        r.message_end  = fin_msg;
        r.status       = st;
        r.last_result  = 1'b0;
        return r;
    endfunction

endpackage

// ===== hdl/wsfd_front.sv =====
// Front end: byte-wise header parser, unmasking and message tracking.
module wsfd_front #(
    parameter int LENGTH_BITS = 23
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [7:0]                     rx_byte,
    input  logic                           cfg_we,
    input  logic [wsfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wsfd_pkg::CFG_W-1:0]     cfg_data,
    output wsfd_pkg::wsfd_wr_t             wr
);
    import wsfd_pkg::*;

    localparam int LB = LENGTH_BITS;
    localparam int CW = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;

    wsfd_phase_t      phase_reg, phase_next;
    logic [2:0]       hc_reg, hc_next;
    logic             fin_reg, fin_next;
    logic [3:0]       op_reg, op_next;
    logic             masked_reg, masked_next;
    logic [LB-1:0]    acc_reg, acc_next;
    logic             over_reg, over_next;
    logic [31:0]      key_reg, key_next;
    logic [LB-1:0]    pidx_reg, pidx_next;
    logic             frag_act_reg, frag_act_next;
    logic [3:0]       frag_op_reg, frag_op_next;
    logic [LB-1:0]    frag_tot_reg, frag_tot_next;
    logic             stop_reg, stop_next;
    logic [CFG_W-1:0] max_frame_reg;
    logic [CFG_W-1:0] max_msg_reg;

    logic [6:0]    code;
    logic [LB-1:0] len_cur;
    logic          over_cur;
    logic          hdr_done;
    logic          too_long;
    logic          len_zero;
    logic [LB:0]   sum;
    logic          msg_over;
    logic          first_over;
    logic          go_data;
    logic          data_last;
    logic [7:0]    key_byte;
    logic [7:0]    data;
    logic          a_v, b_v;
    wsfd_res_t     res_a, res_b;
    logic          step;

    assign step = accept && !stop_reg;
    assign code = rx_byte[6:0];

    // Length as it stands once the last header byte has been taken.
    always_comb
    begin
        len_cur  = acc_reg;
        over_cur = over_reg;
        hdr_done = 1'b0;
        unique case (phase_reg)
            PH_HDR1:
            begin
                len_cur  = LB'(code);
                over_cur = 1'b0;
                hdr_done = (code != LEN_CODE_16) && (code != LEN_CODE_64) && !rx_byte[7];
            end
            PH_EXT:
            begin
                len_cur  = LB'({acc_reg, rx_byte});
                over_cur = over_reg || (acc_reg[LB-1 -: 8] != 8'h00);
                hdr_done = (hc_reg == EXT_LAST) && !masked_reg;
            end
            PH_MASK:
            begin
                hdr_done = (hc_reg == MASK_LAST);
            end
            PH_HDR0, PH_DATA:
            begin
                hdr_done = 1'b0;
            end
            default:
            begin
                hdr_done = 1'b0;
            end
        endcase
    end

    assign too_long   = over_cur || (CW'(len_cur) > CW'(max_frame_reg));
    assign len_zero   = (len_cur == '0);
    assign sum        = (LB+1)'(frag_tot_reg) + (LB+1)'(len_cur);
    assign msg_over   = sum[LB] || ((CW+1)'(sum) > (CW+1)'(max_msg_reg));
    assign first_over = CW'(len_cur) > CW'(max_msg_reg);

    assign data_last = ((LB+1)'(pidx_reg) + (LB+1)'(1)) == (LB+1)'(acc_reg);
    assign key_byte  = 8'(key_reg >> {~pidx_reg[1:0], 3'b000});
    assign data      = masked_reg ? (rx_byte ^ key_byte) : rx_byte;

    // Header decisions, payload results and the next values of the data state.
    always_comb
    begin
        fin_next      = fin_reg;
        op_next       = op_reg;
        masked_next   = masked_reg;
        acc_next      = acc_reg;
        over_next     = over_reg;
        key_next      = key_reg;
        hc_next       = hc_reg;
        pidx_next     = pidx_reg;
        frag_act_next = frag_act_reg;
        frag_op_next  = frag_op_reg;
        frag_tot_next = frag_tot_reg;
        stop_next     = stop_reg;
        a_v           = 1'b0;
        b_v           = 1'b0;
        res_a         = '0;
        res_b         = '0;
        go_data       = 1'b0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                fin_next = rx_byte[7];
                op_next  = rx_byte[3:0];
            end
            PH_HDR1:
            begin
                masked_next = rx_byte[7];
                key_next    = '0;
                over_next   = 1'b0;
                if ((code == LEN_CODE_16) || (code == LEN_CODE_64))
                begin
                    acc_next = '0;
                    hc_next  = (code == LEN_CODE_16) ? EXT16_START : 3'd0;
                end
                else
                begin
                    acc_next = len_cur;
                    hc_next  = 3'd0;
                end
            end
            PH_EXT:
            begin
                acc_next  = len_cur;
                over_next = over_cur;
                hc_next   = hc_reg + 3'd1;
                if (hc_reg == EXT_LAST)
                begin
                    hc_next = 3'd0;
                end
            end
            PH_MASK:
            begin
                key_next = {key_reg[23:0], rx_byte};
                hc_next  = hc_reg + 3'd1;
                if (hc_reg == MASK_LAST)
                begin
                    hc_next = 3'd0;
                end
            end
            PH_DATA:
            begin
                pidx_next = pidx_reg + LB'(1);
                if ((op_reg == OP_TEXT) || (op_reg == OP_BIN))
                begin
                    a_v   = 1'b1;
                    res_a = mk_data(data, op_reg, data_last && fin_reg, ST_DATA);
                end
                else if (op_reg == OP_CONT)
                begin
                    if (frag_act_reg)
                    begin
                        a_v   = 1'b1;
                        res_a = mk_data(data, frag_op_reg, data_last && fin_reg, ST_DATA);
                        if (data_last && fin_reg)
                        begin
                            frag_act_next = 1'b0;
                            frag_op_next  = OP_CONT;
                            frag_tot_next = '0;
                        end
                    end
                end
                else if (op_reg == OP_PING)
                begin
                    if (acc_reg <= LB'(PING_MAX))
                    begin
                        a_v   = 1'b1;
                        res_a = mk_data(data, OP_PING, data_last, ST_PING);
                    end
                end
            end
            default:
            begin
                hc_next = hc_reg;
            end
        endcase

        if (hdr_done)
        begin
            pidx_next = '0;
            if (too_long)
            begin
                a_v       = 1'b1;
                res_a     = mk_marker(op_reg, 1'b0, ST_FRAME_BIG);
                stop_next = 1'b1;
            end
            else if (op_reg == OP_CLOSE)
            begin
                a_v       = 1'b1;
                res_a     = mk_marker(OP_CLOSE, 1'b0, ST_CLOSE);
                stop_next = 1'b1;
            end
            else if ((op_reg == OP_TEXT) || (op_reg == OP_BIN))
            begin
                // A new message while a fragmented one is open drops the old one.
                if (frag_act_reg)
                begin
                    a_v           = 1'b1;
                    res_a         = mk_marker(frag_op_reg, 1'b0, ST_ABANDON);
                    frag_act_next = 1'b0;
                    frag_op_next  = OP_CONT;
                    frag_tot_next = '0;
                end
                if (fin_reg)
                begin
                    if (len_zero)
                    begin
                        b_v   = 1'b1;
                        res_b = mk_marker(op_reg, 1'b1, ST_DATA);
                    end
                    else
                    begin
                        go_data = 1'b1;
                    end
                end
                else if (first_over)
                begin
                    b_v       = 1'b1;
                    res_b     = mk_marker(op_reg, 1'b0, ST_MSG_BIG);
                    stop_next = 1'b1;
                end
                else
                begin
                    frag_act_next = 1'b1;
                    frag_op_next  = op_reg;
                    frag_tot_next = len_cur;
                    go_data       = !len_zero;
                end
            end
            else if (op_reg == OP_CONT)
            begin
                if (frag_act_reg && msg_over)
                begin
                    a_v       = 1'b1;
                    res_a     = mk_marker(frag_op_reg, 1'b0, ST_MSG_BIG);
                    stop_next = 1'b1;
                end
                else
                begin
                    if (frag_act_reg)
                    begin
                        frag_tot_next = LB'(sum);
                    end
                    if (frag_act_reg && len_zero && fin_reg)
                    begin
                        a_v           = 1'b1;
                        res_a         = mk_marker(frag_op_reg, 1'b1, ST_DATA);
                        frag_act_next = 1'b0;
                        frag_op_next  = OP_CONT;
                        frag_tot_next = '0;
                    end
                    go_data = !len_zero;
                end
            end
            else if (op_reg == OP_PING)
            begin
                if (len_zero)
                begin
                    a_v   = 1'b1;
                    res_a = mk_marker(OP_PING, 1'b1, ST_PING);
                end
                else
                begin
                    go_data = 1'b1;
                end
            end
            else
            begin
                go_data = !len_zero;
            end

            if (stop_next)
            begin
                frag_act_next = 1'b0;
                frag_op_next  = OP_CONT;
                frag_tot_next = '0;
            end
        end
    end

    // Next phase of the header parser.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HDR0:
            begin
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                if ((code == LEN_CODE_16) || (code == LEN_CODE_64))
                begin
                    phase_next = PH_EXT;
                end
                else if (rx_byte[7])
                begin
                    phase_next = PH_MASK;
                end
                else
                begin
                    phase_next = go_data ? PH_DATA : PH_HDR0;
                end
            end
            PH_EXT:
            begin
                if (hc_reg == EXT_LAST)
                begin
                    if (masked_reg)
                    begin
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        phase_next = go_data ? PH_DATA : PH_HDR0;
                    end
                end
            end
            PH_MASK:
            begin
                if (hc_reg == MASK_LAST)
                begin
                    phase_next = go_data ? PH_DATA : PH_HDR0;
                end
            end
            PH_DATA:
            begin
                if (data_last)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase
    end

    // Results of this byte, packed to the front and the last one marked.
    always_comb
    begin
        wr       = '0;
        wr.e0    = a_v ? res_a : res_b;
        wr.e1    = res_b;
        if (a_v && b_v)
        begin
            wr.e1.last_result = 1'b1;
        end
        else
        begin
            wr.e0.last_result = 1'b1;
        end
        if (step)
        begin
            wr.count = 2'(a_v) + 2'(b_v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            hc_reg        <= '0;
            fin_reg       <= 1'b0;
            op_reg        <= '0;
            masked_reg    <= 1'b0;
            acc_reg       <= '0;
            over_reg      <= 1'b0;
            key_reg       <= '0;
            pidx_reg      <= '0;
            frag_act_reg  <= 1'b0;
            frag_op_reg   <= '0;
            frag_tot_reg  <= '0;
            stop_reg      <= 1'b0;
            max_frame_reg <= CFG_RESET_LEN;
            max_msg_reg   <= CFG_RESET_LEN;
        end
        else
        begin
            if (step)
            begin
                phase_reg    <= phase_next;
                hc_reg       <= hc_next;
                fin_reg      <= fin_next;
                op_reg       <= op_next;
                masked_reg   <= masked_next;
                acc_reg      <= acc_next;
                over_reg     <= over_next;
                key_reg      <= key_next;
                pidx_reg     <= pidx_next;
                frag_act_reg <= frag_act_next;
                frag_op_reg  <= frag_op_next;
                frag_tot_reg <= frag_tot_next;
                stop_reg     <= stop_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_FRAME_LEN:   max_frame_reg <= cfg_data;
                    REG_MAX_MESSAGE_LEN: max_msg_reg   <= cfg_data;
                    default:             max_msg_reg   <= max_msg_reg;
                endcase
            end
        end
    end

endmodule

// ===== hdl/wsfd_queue.sv =====
// Result queue between the parser and the output side, up to two writes and one read per cycle.
module wsfd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  wsfd_pkg::wsfd_wr_t  wr,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output wsfd_pkg::wsfd_res_t head
);
    import wsfd_pkg::*;

    localparam int CNT_W = Q_AW + 1;

    wsfd_res_t        mem [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             take;

    // Room is kept for the two results that one byte can give.
    assign full  = count_reg > CNT_W'(Q_DEPTH - 2);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];
    assign take  = pop && !empty;

    assign wr_ptr_next = wr_ptr_reg + Q_AW'(wr.count);
    assign rd_ptr_next = rd_ptr_reg + Q_AW'(take);
    assign count_next  = count_reg + CNT_W'(wr.count) - CNT_W'(take);

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr.e0;
        end
        if (wr.count == 2'd2)
        begin
            mem[Q_AW'(wr_ptr_reg + 1'b1)] <= wr.e1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("result queue holds more entries than its depth");

    a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.count != 2'd0) |-> !full)
        else $error("results written while the queue is full");

    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr.count != 2'd3)
        else $error("more than two results for one byte");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((wr.count == 2'd0) && !take) |=> $stable(count_reg) && $stable(rd_ptr_reg))
        else $error("queue changed with no write and no pop");

endmodule

// ===== hdl/websocket_frame_deframer_top.sv =====
// Top level of the WebSocket frame deframer: parser front end and result queue.
//
//  Channel   Handshake              Beat contents
//  input     push / full            rx_byte
//  result    pop / empty            payload_byte, byte_valid, msg_opcode, message_end,
//                                   status, last_result
//  config    cfg_we                 cfg_index, cfg_data (no wait, no read-back)
//
// One received byte is taken every cycle while full is low; the parser updates its state registers per byte.
// Results are written into a four-entry queue, whose head drives the result ports.
// full rises while the queue holds more than two results, since a byte at the end of a
// header can give two; a stalled reader therefore stops the input once three or four
// results are waiting, however many header beats that takes.
// Reset is asynchronous and active low; there is no clearing pass after it.
module websocket_frame_deframer_top #(
    parameter int LENGTH_BITS = 23
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     rx_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     payload_byte,
    output logic                           byte_valid,
    output logic [3:0]                     msg_opcode,
    output logic                           message_end,
    output logic [2:0]                     status,
    output logic                           last_result,
    input  logic                           cfg_we,
    input  logic [wsfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wsfd_pkg::CFG_W-1:0]     cfg_data
);
    import wsfd_pkg::*;

    wsfd_wr_t  wr;
    wsfd_res_t head;
    logic      accept;

    assign accept = push && !full;

    wsfd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr        (wr)
    );

    wsfd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .pop   (pop),
        .full  (full),
        .empty (empty),
        .head  (head)
    );

    assign payload_byte = head.payload_byte;
    assign byte_valid   = head.byte_valid;
    assign msg_opcode   = head.msg_opcode;
    assign message_end  = head.message_end;
    assign status       = head.status;
    assign last_result  = head.last_result;

endmodule

// ===== test/websocket_frame_deframer_checker.sv =====
// Checker for the WebSocket frame deframer: predicts every result beat and compares it.
`timescale 1ns / 1ps

module websocket_frame_deframer_checker #(
    parameter int LENGTH_BITS = 23
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic [7:0]                     rx_byte,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [7:0]                     payload_byte,
    input  logic                           byte_valid,
    input  logic [3:0]                     msg_opcode,
    input  logic                           message_end,
    input  logic [2:0]                     status,
    input  logic                           last_result,
    input  logic                           cfg_we,
    input  logic [wsfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wsfd_pkg::CFG_W-1:0]     cfg_data,
    output int                             mismatches,
    output int                             deframed_pending
);
    import wsfd_pkg::*;

    localparam logic [63:0] LEN_LIMIT = (64'd1 << LENGTH_BITS) - 64'd1;

    logic [CFG_W-1:0]       frame_max;
    logic [CFG_W-1:0]       message_max;
    wsfd_phase_t            phase;
    logic [3:0]             hdr_count;
    logic                   fin;
    logic [3:0]             frame_op;
    logic                   masked;
    logic [63:0]            len_word;
    logic [31:0]            mask_word;
    logic [LENGTH_BITS-1:0] pay_idx;
    logic                   frag_open;
    logic [3:0]             frag_op;
    logic [63:0]            frag_total;
    logic                   halted;
    int                     step_results;

    wsfd_res_t deframed_out[$];
    wsfd_res_t seen;
    wsfd_res_t want;

    task automatic emit(input logic [7:0] data, input logic valid, input logic [3:0] op,
                        input logic msg_end, input logic [2:0] st);
        wsfd_res_t r;
        r.payload_byte = data;
        r.byte_valid   = valid;
        r.msg_opcode   = op;
        r.message_end  = msg_end;
        r.status       = st;
        r.last_result  = 1'b0;
        deframed_out.push_back(r);
        step_results++;
    endtask

    task automatic drop_message();
        frag_open  = 1'b0;
        frag_op    = OP_CONT;
        frag_total = 64'd0;
    endtask

    task automatic stop_block();
        drop_message();
        halted = 1'b1;
    endtask

    // Runs once the length and any mask key of a frame are complete.
    task automatic close_header();
        pay_idx = '0;
        phase   = PH_HDR0;
        if (len_word > 64'(frame_max) || len_word > LEN_LIMIT)
        begin
            emit(8'h00, 1'b0, frame_op, 1'b0, ST_FRAME_BIG);
            stop_block();
        end
        else
        begin
            unique case (frame_op)
                OP_CLOSE:
                begin
                    emit(8'h00, 1'b0, OP_CLOSE, 1'b0, ST_CLOSE);
                    stop_block();
                end
                OP_TEXT, OP_BIN:
                begin
                    if (frag_open)
                    begin
                        emit(8'h00, 1'b0, frag_op, 1'b0, ST_ABANDON);
                        drop_message();
                    end
                    if (fin)
                    begin
                        if (len_word == 64'd0)
                            emit(8'h00, 1'b0, frame_op, 1'b1, ST_DATA);
                        else
                            phase = PH_DATA;
                    end
                    else if (len_word > 64'(message_max))
                    begin
                        emit(8'h00, 1'b0, frame_op, 1'b0, ST_MSG_BIG);
                        stop_block();
                    end
                    else
                    begin
                        frag_open  = 1'b1;
                        frag_op    = frame_op;
                        frag_total = len_word;
                        if (len_word != 64'd0)
                            phase = PH_DATA;
                    end
                end
                OP_CONT:
                begin
                    if (frag_open && (frag_total + len_word > 64'(message_max) ||
                                      frag_total + len_word > LEN_LIMIT))
                    begin
                        emit(8'h00, 1'b0, frag_op, 1'b0, ST_MSG_BIG);
                        stop_block();
                    end
                    else
                    begin
                        if (frag_open)
                            frag_total = frag_total + len_word;
                        if (len_word != 64'd0)
                            phase = PH_DATA;
                        else if (frag_open && fin)
                        begin
                            emit(8'h00, 1'b0, frag_op, 1'b1, ST_DATA);
                            drop_message();
                        end
                    end
                end
                OP_PING:
                begin
                    if (len_word == 64'd0)
                        emit(8'h00, 1'b0, OP_PING, 1'b1, ST_PING);
                    else
                        phase = PH_DATA;
                end
                default:
                begin
                    if (len_word != 64'd0)
                        phase = PH_DATA;
                end
            endcase
        end
    endtask

    task automatic deframe_rx_byte(input logic [7:0] b);
        logic       is_last;
        logic [7:0] data;
        wsfd_res_t  r;
        step_results = 0;
        if (!halted)
        begin
            unique case (phase)
                PH_HDR0:
                begin
                    fin      = b[7];
                    frame_op = b[3:0];
                    phase    = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked    = b[7];
                    mask_word = 32'd0;
                    len_word  = 64'd0;
                    if (b[6:0] == LEN_CODE_16 || b[6:0] == LEN_CODE_64)
                    begin
                        hdr_count = (b[6:0] == LEN_CODE_16) ? 4'd6 : 4'd0;
                        phase     = PH_EXT;
                    end
                    else
                    begin
                        len_word  = {57'd0, b[6:0]};
                        hdr_count = 4'd0;
                        if (masked)
                            phase = PH_MASK;
                        else
                            close_header();
                    end
                end
                PH_EXT:
                begin
                    len_word  = {len_word[55:0], b};
                    hdr_count = hdr_count + 4'd1;
                    if (hdr_count >= 4'd8)
                    begin
                        hdr_count = 4'd0;
                        if (masked)
                            phase = PH_MASK;
                        else
                            close_header();
                    end
                end
                PH_MASK:
                begin
                    mask_word = {mask_word[23:0], b};
                    hdr_count = hdr_count + 4'd1;
                    if (hdr_count >= 4'd4)
                    begin
                        hdr_count = 4'd0;
                        close_header();
                    end
                end
                PH_DATA:
                begin
                    is_last = (64'(pay_idx) + 64'd1) == len_word;
                    // The first key byte received unmasks payload bytes 0, 4, 8 and so on.
                    data = masked ? (b ^ mask_word[8 * (3 - pay_idx[1:0]) +: 8]) : b;
                    unique case (frame_op)
                        OP_TEXT, OP_BIN:
                            emit(data, 1'b1, frame_op, is_last && fin, ST_DATA);
                        OP_CONT:
                        begin
                            if (frag_open)
                            begin
                                emit(data, 1'b1, frag_op, is_last && fin, ST_DATA);
                                if (is_last && fin)
                                    drop_message();
                            end
                        end
                        OP_PING:
                        begin
                            if (len_word <= 64'(PING_MAX))
                                emit(data, 1'b1, OP_PING, is_last, ST_PING);
                        end
                        default: ;
                    endcase
                    pay_idx = pay_idx + 1'b1;
                    if (is_last)
                        phase = PH_HDR0;
                end
                default: phase = PH_HDR0;
            endcase
        end
        if (step_results > 0)
        begin
            r = deframed_out.pop_back();
            r.last_result = 1'b1;
            deframed_out.push_back(r);
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_max   = CFG_RESET_LEN;
            message_max = CFG_RESET_LEN;
            phase       = PH_HDR0;
            hdr_count   = 4'd0;
            fin         = 1'b0;
            frame_op    = OP_CONT;
            masked      = 1'b0;
            len_word    = 64'd0;
            mask_word   = 32'd0;
            pay_idx     = '0;
            halted      = 1'b0;
            drop_message();
            deframed_out.delete();
            deframed_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_FRAME_LEN)
                    frame_max = cfg_data;
                else if (cfg_index == REG_MAX_MESSAGE_LEN)
                    message_max = cfg_data;
            end
            if (push && !full)
                deframe_rx_byte(rx_byte);
            if (pop && !empty)
            begin
                seen.payload_byte = payload_byte;
                seen.byte_valid   = byte_valid;
                seen.msg_opcode   = msg_opcode;
                seen.message_end  = message_end;
                seen.status       = status;
                seen.last_result  = last_result;
                if (deframed_out.size() == 0)
                begin
                    $error("result beat with nothing outstanding: %p", seen);
                    mismatches++;
                end
                else
                begin
                    want = deframed_out.pop_front();
                    check_field("payload_byte", want.payload_byte, seen.payload_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(seen.byte_valid));
                    check_field("msg_opcode", 8'(want.msg_opcode), 8'(seen.msg_opcode));
                    check_field("message_end", 8'(want.message_end), 8'(seen.message_end));
                    check_field("status", 8'(want.status), 8'(seen.status));
                    check_field("last_result", 8'(want.last_result), 8'(seen.last_result));
                end
            end
            deframed_pending <= deframed_out.size();
        end
    end

endmodule

// ===== test/websocket_frame_deframer_top_tb.sv =====
// Testbench top for the WebSocket frame deframer: frame stimulus, reader and verdict.
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb;
    import wsfd_pkg::*;

    localparam logic [3:0] OP_PONG      = 4'hA;
    localparam logic [3:0] OP_RSVD_DATA = 4'h3;
    localparam logic [3:0] OP_RSVD_CTRL = 4'hF;
    localparam int RSVD_DATA_HI = 7;
    localparam int RSVD_CTRL_LO = 11;

    localparam int FORM_7  = 0;
    localparam int FORM_16 = 1;
    localparam int FORM_64 = 2;

    localparam int K_MSG  = 0;
    localparam int K_CONT = 1;
    localparam int K_CTRL = 2;

    localparam int CFG_TOP_LEN    = 4194304;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    logic [7:0]           rx_byte   = 8'h00;
    logic                 empty;
    logic                 pop       = 1'b0;
    logic [7:0]           payload_byte;
    logic                 byte_valid;
    logic [3:0]           msg_opcode;
    logic                 message_end;
    logic [2:0]           status;
    logic                 last_result;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_FRAME_LEN;
    logic [CFG_W-1:0]     cfg_data  = '0;
    int                   mismatches;
    int                   deframed_pending;

    logic [7:0] wire_bytes[$];
    int         frame_lim = int'(CFG_RESET_LEN);
    int         msg_lim   = int'(CFG_RESET_LEN);
    bit         gen_open  = 1'b0;
    int         gen_total = 0;
    int         bytes_sent = 0;
    int         quiet_cycles = 0;

    websocket_frame_deframer_top uut (.*);

    websocket_frame_deframer_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Reader: random stalls, one idle-free stretch, and one long hold-off so that input backs up.
    initial
    begin
        int popped;
        bit held;
        popped = 0;
        held   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && popped >= 150)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            pop <= (popped >= 200 && popped < 350) || ($urandom_range(99) >= 15);
            @(posedge clk);
            if (pop && !empty)
                popped++;
        end
    end

    function automatic int min_of(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int pick_len(input int cap);
        int n;
        int r;
        r = $urandom_range(99);
        if (r < 10)
            n = 0;
        else if (r < 75)
            n = $urandom_range(16, 1);
        else if (r < 93)
            n = $urandom_range(140, 17);
        else
            n = $urandom_range(700, 141);
        if (n > cap)
            n = $urandom_range(cap, 0);
        return n;
    endfunction

    task automatic queue_frame(input bit fin_bit, input logic [3:0] op, input logic [63:0] len,
                               input int body, input int form, input bit mask_on);
        logic [31:0] mask_word;
        int i;
        mask_word = $urandom;
        wire_bytes.push_back({fin_bit, 3'($urandom), op});
        if (form == FORM_7)
        begin
            wire_bytes.push_back({mask_on, len[6:0]});
        end
        else if (form == FORM_16)
        begin
            wire_bytes.push_back({mask_on, LEN_CODE_16});
            wire_bytes.push_back(len[15:8]);
            wire_bytes.push_back(len[7:0]);
        end
        else
        begin
            wire_bytes.push_back({mask_on, LEN_CODE_64});
            for (i = 7; i >= 0; i--)
                wire_bytes.push_back(len[8 * i +: 8]);
        end
        if (mask_on)
            for (i = 3; i >= 0; i--)
                wire_bytes.push_back(mask_word[8 * i +: 8]);
        for (i = 0; i < body; i++)
            wire_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Mostly the shortest length form, sometimes a longer one that is still legal.
    task automatic queue_sized(input bit fin_bit, input logic [3:0] op, input int len,
                               input bit mask_on);
        int r;
        int form;
        r = $urandom_range(9);
        if (len <= 125)
            form = (r < 8) ? FORM_7 : ((r == 8) ? FORM_16 : FORM_64);
        else if (len <= 65535)
            form = (r < 7) ? FORM_16 : FORM_64;
        else
            form = FORM_64;
        queue_frame(fin_bit, op, 64'(len), len, form, mask_on);
    endtask

    task automatic queue_random_frame();
        int pick;
        int kind;
        int len;
        int sel;
        bit fin_bit;
        logic [3:0] op;
        pick    = $urandom_range(99);
        fin_bit = 1'($urandom_range(1));
        if (gen_open)
            kind = (pick < 60) ? K_CONT : ((pick < 85) ? K_CTRL : K_MSG);
        else
            kind = (pick < 55) ? K_MSG : ((pick < 90) ? K_CTRL : K_CONT);
        case (kind)
            K_MSG:
            begin
                // A new data frame while a message is open abandons that message.
                op      = $urandom_range(1) ? OP_TEXT : OP_BIN;
                fin_bit = $urandom_range(9) < 6;
                if (fin_bit)
                begin
                    len      = pick_len(frame_lim);
                    gen_open = 1'b0;
                end
                else
                begin
                    len       = pick_len(min_of(frame_lim, msg_lim));
                    gen_open  = 1'b1;
                    gen_total = len;
                end
                queue_sized(fin_bit, op, len, 1'($urandom_range(1)));
            end
            K_CONT:
            begin
                fin_bit = $urandom_range(9) < 4;
                if (gen_open)
                begin
                    len       = pick_len(min_of(frame_lim, msg_lim - gen_total));
                    gen_total = gen_total + len;
                    if (fin_bit)
                        gen_open = 1'b0;
                end
                else
                begin
                    len = pick_len(frame_lim);
                end
                queue_sized(fin_bit, OP_CONT, len, 1'($urandom_range(1)));
            end
            default:
            begin
                sel = $urandom_range(9);
                if (sel < 5)
                begin
                    op = OP_PING;
                    if ($urandom_range(9) == 0 && frame_lim >= 140)
                        len = $urandom_range(140, 126);
                    else
                        len = pick_len(min_of(int'(PING_MAX), frame_lim));
                end
                else
                begin
                    if (sel < 7)
                        op = OP_PONG;
                    else if ($urandom_range(1))
                        op = 4'($urandom_range(RSVD_DATA_HI, OP_RSVD_DATA));
                    else
                        op = 4'($urandom_range(OP_RSVD_CTRL, RSVD_CTRL_LO));
                    len = pick_len(frame_lim);
                end
                queue_sized(fin_bit, op, len, 1'($urandom_range(1)));
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (!(bytes_sent >= 300 && bytes_sent < 500) && $urandom_range(99) < 15)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_stream();
        while (wire_bytes.size() > 0)
            send_byte(wire_bytes.pop_front());
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (deframed_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(input int frame_cap, input int msg_cap);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_FRAME_LEN;
        cfg_data  <= CFG_W'(frame_cap);
        @(posedge clk);
        cfg_index <= REG_MAX_MESSAGE_LEN;
        cfg_data  <= CFG_W'(msg_cap);
        @(posedge clk);
        cfg_we    <= 1'b0;
        frame_lim = frame_cap;
        msg_lim   = msg_cap;
    endtask

    // Random frames until the byte budget is used, then the open message is closed.
    task automatic run_random(input int budget);
        while (wire_bytes.size() < budget)
            queue_random_frame();
        if (gen_open)
        begin
            queue_sized(1'b1, OP_CONT, 0, 1'($urandom_range(1)));
            gen_open = 1'b0;
        end
        send_stream();
        drain_results();
    endtask

    task automatic queue_directed();
        queue_frame(1'b1, OP_TEXT, 5, 5, FORM_7, 1'b1);
        queue_frame(1'b1, OP_BIN, 3, 3, FORM_16, 1'b0);
        queue_frame(1'b1, OP_TEXT, 0, 0, FORM_7, 1'b1);
        queue_frame(1'b1, OP_PING, 0, 0, FORM_7, 1'b0);
        queue_frame(1'b0, OP_PING, 4, 4, FORM_7, 1'b1);
        // Fragmented message with control frames in between and an empty final piece.
        queue_frame(1'b0, OP_TEXT, 2, 2, FORM_7, 1'b0);
        queue_frame(1'b1, OP_PING, 1, 1, FORM_7, 1'b1);
        queue_frame(1'b1, OP_PONG, 2, 2, FORM_7, 1'b0);
        queue_frame(1'b0, OP_CONT, 2, 2, FORM_64, 1'b1);
        queue_frame(1'b1, OP_CONT, 0, 0, FORM_7, 1'b0);
        queue_frame(1'b0, OP_BIN, 3, 3, FORM_7, 1'b1);
        queue_frame(1'b1, OP_CONT, 2, 2, FORM_64, 1'b0);
        // Continuation with no message open.
        queue_frame(1'b1, OP_CONT, 3, 3, FORM_7, 1'b1);
        queue_frame(1'b0, OP_TEXT, 2, 2, FORM_7, 1'b0);
        queue_frame(1'b1, OP_BIN, 1, 1, FORM_7, 1'b1);
        queue_frame(1'b0, OP_TEXT, 0, 0, FORM_16, 1'b0);
        queue_frame(1'b0, OP_BIN, 0, 0, FORM_7, 1'b1);
        queue_frame(1'b1, OP_CONT, 0, 0, FORM_7, 1'b0);
        queue_frame(1'b1, OP_RSVD_DATA, 2, 2, FORM_7, 1'b1);
        queue_frame(1'b1, OP_RSVD_CTRL, 0, 0, FORM_7, 1'b0);
        queue_frame(1'b1, OP_PING, 126, 126, FORM_16, 1'b1);
        queue_frame(1'b1, OP_PING, 125, 125, FORM_7, 1'b0);
        queue_frame(1'b1, OP_TEXT, 130, 130, FORM_64, 1'b1);
    endtask

    // Every ending stops the block for good, so one is picked per run.
    task automatic queue_ending();
        logic [63:0] huge;
        case ($urandom_range(4))
            0:
            begin
                write_limits(int'(CFG_RESET_LEN), int'(CFG_RESET_LEN));
                queue_sized(1'b1, OP_CLOSE, $urandom_range(10), 1'($urandom_range(1)));
            end
            1:
            begin
                write_limits(10, 100);
                queue_sized(1'b1, OP_TEXT, 11, 1'($urandom_range(1)));
            end
            2:
            begin
                // Limit register all ones, so only the length range can reject the frame.
                write_limits(int'(CFG_W'('1)), int'(CFG_W'('1)));
                huge = {32'($urandom), 32'($urandom)} | (64'd1 << CFG_W);
                queue_frame(1'b1, OP_BIN, huge, 8, FORM_64, 1'($urandom_range(1)));
            end
            3:
            begin
                write_limits(100, 20);
                queue_sized(1'b0, OP_TEXT, 12, 1'($urandom_range(1)));
                queue_sized(1'b1, OP_CONT, 12, 1'($urandom_range(1)));
            end
            default:
            begin
                write_limits(100, 5);
                queue_sized(1'b0, OP_BIN, 6, 1'($urandom_range(1)));
            end
        endcase
        repeat (20) wire_bytes.push_back(8'($urandom_range(255)));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_directed();
        send_stream();
        drain_results();

        write_limits(CFG_TOP_LEN, CFG_TOP_LEN);
        run_random(120);
        write_limits(64, 200);
        run_random(60);
        // With both limits at zero only empty frames keep the block running.
        write_limits(0, 0);
        run_random(30);

        queue_ending();
        send_stream();
        drain_results();

        if (mismatches == 0 && deframed_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
